>>> design/bri_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bri_pkg
// Shared types, widths, command codes and the word popcount of the bitmap
// rank index.
// ----------------------------------------------------------------------------
package bri_pkg;

  // bitmap geometry
  localparam int MASK_WORDS   = 512;
  localparam int WORD_W       = 64;
  localparam int BIT_W        = 6;
  localparam int POS_W        = 15;
  localparam int CMD_W        = 2;
  localparam int RANK_W       = 15;
  localparam int PC_W         = 7;
  localparam int RUN_W        = RANK_W + 1;
  localparam int WORD_FIELD_W = POS_W - BIT_W;
  localparam int IDX_W        = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;

  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};
  localparam logic [RUN_W-1:0]  RUN_CAP  = {1'b1, {RANK_W{1'b0}}};

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BUILD = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic              present;
    logic [RANK_W-1:0] rank;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_BUILD,
    ST_BUILD_DRAIN,
    ST_QRY_RD,
    ST_QRY_CNT,
    ST_QRY_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic item_load;
    logic cnt_inc;
    logic clr_wr;
    logic mark_rd;
    logic mark_wr;
    logic bld_rd;
    logic qry_rd;
    logic qry_cnt;
    logic out_load;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_last;
    logic bld_busy;
    logic out_free;
  } stat_t;

  // adder tree popcount of one word
  function automatic logic [PC_W-1:0] popcount64(input logic [WORD_W-1:0] v);
    logic [1:0] s1 [32];
    logic [2:0] s2 [16];
    logic [3:0] s3 [8];
    logic [4:0] s4 [4];
    logic [5:0] s5 [2];
    for (int i = 0; i < 32; i++) s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 16; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    for (int i = 0; i < 8; i++)  s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    for (int i = 0; i < 4; i++)  s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    for (int i = 0; i < 2; i++)  s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    return {1'b0, s5[0]} + {1'b0, s5[1]};
  endfunction

endpackage
`default_nettype wire

>>> design/bri_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bri_ctrl
// Command sequencer: steps through clear sweeps, mark read-modify-write,
// prefix build sweep and rank query.
// ----------------------------------------------------------------------------
module bri_ctrl
  import bri_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [CMD_W-1:0] in_command,
  output logic                  in_stall,
  input  wire stat_t            stat,
  output ctl_t                  ctl
);

  state_t state_r, state_nxt;

  // state register, reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.cnt_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_MARK:  state_nxt = ST_MARK_RD;
            CMD_BUILD: state_nxt = ST_BUILD;
            CMD_QUERY: state_nxt = ST_QRY_RD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MARK_RD:     state_nxt = ST_MARK_WR;
      ST_MARK_WR:     state_nxt = ST_IDLE;
      ST_BUILD: begin
        if (stat.cnt_last) state_nxt = ST_BUILD_DRAIN;
      end
      ST_BUILD_DRAIN: begin
        if (!stat.bld_busy) state_nxt = ST_IDLE;
      end
      ST_QRY_RD:      state_nxt = ST_QRY_CNT;
      ST_QRY_CNT:     state_nxt = ST_QRY_OUT;
      ST_QRY_OUT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default:        state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        ctl.clr_wr  = 1'b1;
        ctl.cnt_inc = 1'b1;
      end
      ST_IDLE: begin
        in_stall      = 1'b0;
        ctl.item_load = in_valid;
      end
      ST_MARK_RD:     ctl.mark_rd = 1'b1;
      ST_MARK_WR:     ctl.mark_wr = 1'b1;
      ST_BUILD: begin
        ctl.bld_rd  = 1'b1;
        ctl.cnt_inc = 1'b1;
      end
      ST_BUILD_DRAIN: ctl = '0;
      ST_QRY_RD:      ctl.qry_rd = 1'b1;
      ST_QRY_CNT:     ctl.qry_cnt = 1'b1;
      ST_QRY_OUT:     ctl.out_load = stat.out_free;
      default:        ctl = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> design/bri_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bri_datapath
// Occupancy and prefix memories, sweep counter, build pipeline with running
// count, query popcount and the result register.
// ----------------------------------------------------------------------------
module bri_datapath
  import bri_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ctl_t     ctl,
  output stat_t         stat,
  input  wire in_item_t in_data,
  input  wire logic     out_stall,
  output logic          out_valid,
  output out_item_t     out_data
);

  logic [WORD_W-1:0] occ_mem [MASK_WORDS];
  logic [RANK_W-1:0] pre_mem [MASK_WORDS];

  in_item_t          item_r;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] occ_rd_r;
  logic [RANK_W-1:0] pre_rd_r;
  logic              b1_v_r, b2_v_r;
  logic [IDX_W-1:0]  b1_a_r, b2_a_r;
  logic [PC_W-1:0]   b2_pc_r;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic [RUN_W:0]    run_sum;
  logic              q_hit_r;
  logic [PC_W-1:0]   q_pc_r;
  logic [RANK_W-1:0] q_pre_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [WORD_FIELD_W-1:0] word;
  logic [BIT_W-1:0]        bit_sel;
  logic [IDX_W-1:0]        word_idx;
  logic                    in_range;
  logic [WORD_W-1:0]       bit_mask;
  logic                    occ_rd_en, occ_we, pre_we;
  logic [IDX_W-1:0]        occ_ra, occ_wa, pre_wa;
  logic [WORD_W-1:0]       occ_wd;
  logic [RANK_W-1:0]       pre_wd, run_sat;
  logic [RANK_W:0]         rank_sum;

  // item register
  always_ff @(posedge clk) begin
    if (ctl.item_load) item_r <= in_data;
  end

  // position decode
  assign word     = item_r.position[POS_W-1:BIT_W];
  assign bit_sel  = item_r.position[BIT_W-1:0];
  assign word_idx = IDX_W'(word);
  assign in_range = 32'(word) < 32'(MASK_WORDS);
  assign bit_mask = WORD_W'(1) << bit_sel;

  // sweep counter, returns to zero after the last word
  assign stat.cnt_last = (32'(cnt_r) == 32'(MASK_WORDS - 1));
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.cnt_inc) cnt_nxt = stat.cnt_last ? '0 : cnt_r + IDX_W'(1);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // occupancy memory ports
  assign occ_rd_en = ctl.mark_rd | ctl.bld_rd | ctl.qry_rd;
  assign occ_ra    = ctl.bld_rd ? cnt_r : word_idx;
  assign occ_we    = ctl.clr_wr | (ctl.mark_wr & in_range);
  assign occ_wa    = ctl.clr_wr ? cnt_r : word_idx;
  assign occ_wd    = ctl.clr_wr ? '0 : (occ_rd_r | bit_mask);

  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[occ_wa] <= occ_wd;
  end
  always_ff @(posedge clk) begin
    if (occ_rd_en) occ_rd_r <= occ_mem[occ_ra];
  end

  // prefix memory ports
  assign run_sat = (run_r > RUN_W'(RANK_MAX)) ? RANK_MAX : run_r[RANK_W-1:0];
  assign pre_we  = ctl.clr_wr | b2_v_r;
  assign pre_wa  = ctl.clr_wr ? cnt_r : b2_a_r;
  assign pre_wd  = ctl.clr_wr ? '0 : run_sat;

  always_ff @(posedge clk) begin
    if (pre_we) pre_mem[pre_wa] <= pre_wd;
  end
  always_ff @(posedge clk) begin
    if (ctl.qry_rd) pre_rd_r <= pre_mem[word_idx];
  end

  // build pipeline: read, popcount, prefix write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
    end else begin
      b1_v_r <= ctl.bld_rd;
      b2_v_r <= b1_v_r;
    end
  end
  always_ff @(posedge clk) begin
    b1_a_r  <= cnt_r;
    b2_a_r  <= b1_a_r;
    b2_pc_r <= popcount64(occ_rd_r);
  end
  assign stat.bld_busy = b1_v_r | b2_v_r;

  // running count, saturating one above the rank range
  assign run_sum = {1'b0, run_r} + (RUN_W + 1)'(b2_pc_r);
  always_comb begin
    run_nxt = run_r;
    if (ctl.bld_rd && cnt_r == '0) begin
      run_nxt = '0;
    end else if (b2_v_r) begin
      run_nxt = (run_sum > (RUN_W + 1)'(RUN_CAP)) ? RUN_CAP : run_sum[RUN_W-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else begin
      run_r <= run_nxt;
    end
  end

  // query: bit test and popcount of the lower bits
  always_ff @(posedge clk) begin
    if (ctl.qry_cnt) begin
      q_hit_r <= in_range & occ_rd_r[bit_sel];
      q_pc_r  <= popcount64(occ_rd_r & (bit_mask - WORD_W'(1)));
      q_pre_r <= pre_rd_r;
    end
  end
  assign rank_sum = {1'b0, q_pre_r} + (RANK_W + 1)'(q_pc_r);

  // result register
  assign stat.out_free = !out_valid_r || !out_stall;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_r.present <= q_hit_r;
      if (!q_hit_r) begin
        out_r.rank <= '0;
      end else if (rank_sum > (RANK_W + 1)'(RANK_MAX)) begin
        out_r.rank <= RANK_MAX;
      end else begin
        out_r.rank <= rank_sum[RANK_W-1:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // a mark write never overlaps a build sweep
  a_mark_vs_build: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.mark_wr && (ctl.bld_rd || b2_v_r)))
    else $error("mark write during prefix build");

  // a result appears only from a query load
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.out_load))
    else $error("result valid without query load");

  // absent bit carries rank zero
  a_absent_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.present) |-> (out_r.rank == '0))
    else $error("nonzero rank for absent bit");

  // prefix writes follow a read stage
  a_build_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    b2_v_r |-> $past(b1_v_r))
    else $error("build write without read stage");
`endif

endmodule
`default_nettype wire

>>> design/bitmap_rank_index.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_rank_index
// Occupancy bitmap with a per-word prefix count, answering rank queries.
// ----------------------------------------------------------------------------
// One command is handled at a time. A rank query passes the states read,
// count and output before its result is loaded and the next command is taken;
// it waits in the output state while a stalled result still holds the output
// register. A mark is a read-modify-write on the occupancy memory, which has
// one read and one write port. Clear and prefix build sweep the memories one
// word per cycle; build runs through a read, popcount, prefix write pipeline.
// After reset a clearing pass over all MASK_WORDS words runs before the first
// command is taken. A finished result sits in an output register, so the next
// command is taken while it waits. Queries use the prefixes of the last build; a clear zeroes them.
// ----------------------------------------------------------------------------
module bitmap_rank_index
  import bri_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  ctl_t  ctl;
  stat_t stat;

  // command sequencer
  bri_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .stat       (stat),
    .ctl        (ctl)
  );

  // memories and arithmetic
  bri_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .stat      (stat),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
